FILE: hw/rtl/lrs_pkg.sv
// Shared types, constants and digit helpers for the LSD decimal radix sorter.
package lrs_pkg;

  localparam int unsigned KeyW      = 32;
  localparam int unsigned WordNibs  = 8;
  localparam int unsigned NumRadix  = 10;
  localparam int unsigned RadixW    = 4;
  localparam int unsigned PosW      = 4;
  localparam logic [RadixW-1:0] TopDigit = 4'd9;

  // Operations of the shared counter unit.
  typedef enum logic [2:0] {
    CNT_IDLE,
    CNT_CLEAR,
    CNT_INC,
    CNT_PREFIX,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    cnt_op_e           op;
    logic [RadixW-1:0] sel;
  } cnt_cmd_t;

  // Decimal digit at a nibble position; nibbles above nine count as nine.
  function automatic logic [RadixW-1:0] lrs_digit(input logic [KeyW-1:0] key,
                                                  input logic [2:0]      pos);
    logic [3:0] nib;
    nib = key[{pos, 2'b00} +: 4];
    return (nib > TopDigit) ? TopDigit : nib;
  endfunction

  // Number of nibbles up to and including the top nonzero one.
  function automatic logic [PosW-1:0] lrs_span(input logic [KeyW-1:0] key);
    logic [PosW-1:0] span;
    span = '0;
    for (int p = 0; p < WordNibs; p++) begin
      if (key[4*p +: 4] != 4'd0) begin
        span = PosW'(p + 1);
      end
    end
    return span;
  endfunction

endpackage

FILE: hw/rtl/lrs_if.sv
// Valid/ready channel interfaces for keys in and sorted keys out.
interface lrs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_bcd;
  logic        last_key;

  modport source (output valid, output key_bcd, output last_key, input ready);
  modport sink   (input valid, input key_bcd, input last_key, output ready);
endinterface

interface lrs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_key;
  logic        last_out;

  modport source (output valid, output sorted_key, output last_out, input ready);
  modport sink   (input valid, input sorted_key, input last_out, output ready);
endinterface

FILE: hw/rtl/lsd_decimal_radix_sort.sv
// Top level: LSD decimal radix sorter of packed-BCD keys with a small sequencer.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------
//  keys_i  | in  | valid/ready, sink   | key_bcd[31:0], last_key
//  keys_o  | out | valid/ready, source | sorted_key[31:0], last_out
//
// Loading accepts one key per cycle while keys_i.valid is high; keys_i.ready is high only while loading.
// Once the last key arrives, each digit pass runs a clear, a count sweep over
// the source buffer, ten prefix steps through the shared adder and a placement
// sweep. Passes run up to the top nonzero digit of the largest key, at most
// DIGITS; then each sorted key is read from the buffer and held on keys_o
// until keys_o.ready takes it.
// Reset clears the sequencer, counters and key count; the key buffers are
// not cleared and need no clearing pass.
module lsd_decimal_radix_sort #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned DIGITS   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrs_in_if.sink     keys_i,
  lrs_out_if.source  keys_o
);
  import lrs_pkg::*;

  localparam int unsigned CntW     = $clog2(MAX_KEYS + 1);
  localparam int unsigned AddrW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned MaskBits = (DIGITS >= WordNibs) ? KeyW : 4 * DIGITS;
  localparam logic [KeyW-1:0] KeyMask = KeyW'((64'd1 << MaskBits) - 64'd1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_KEYS);

  typedef enum logic [6:0] {
    ST_LOAD     = 7'b0000001,
    ST_CLR      = 7'b0000010,
    ST_COUNT    = 7'b0000100,
    ST_PREFIX   = 7'b0001000,
    ST_PLACE    = 7'b0010000,
    ST_OUT_RD   = 7'b0100000,
    ST_OUT_HOLD = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] key_count_q, key_count_d;
  logic [KeyW-1:0] largest_q, largest_d;
  logic            sel_q, sel_d;      // buffer holding the current key order
  logic [PosW-1:0] pos_q, pos_d;      // digit pass
  logic [CntW-1:0] idx_q, idx_d;      // sweep index
  logic [RadixW-1:0] dig_q, dig_d;    // prefix step
  logic            rv_q, rv_d;        // read data valid this cycle

  logic            ram_we, wr_other, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [KeyW-1:0] ram_wdata, rdata_a, rdata_b, rdata;
  logic            wr_sel;
  cnt_cmd_t        cnt_cmd;
  logic [CntW-1:0] cnt_res;
  logic [PosW-1:0] span_raw, span;
  logic [KeyW-1:0] key_in;
  logic [RadixW-1:0] rd_digit;
  logic            out_last;

  assign key_in   = keys_i.key_bcd & KeyMask;
  assign rdata    = sel_q ? rdata_b : rdata_a;
  assign rd_digit = lrs_digit(rdata, pos_q[2:0]);
  assign out_last = (idx_q + CntW'(1)) == key_count_q;

  // Number of passes, capped at the configured digit count.
  assign span_raw = lrs_span(largest_q);
  assign span     = (32'(span_raw) > DIGITS) ? PosW'(DIGITS) : span_raw;

  assign keys_i.ready      = (state_q == ST_LOAD);
  assign keys_o.valid      = (state_q == ST_OUT_HOLD);
  assign keys_o.sorted_key = rdata;
  assign keys_o.last_out   = out_last;

  always_comb begin
    state_d     = state_q;
    key_count_d = key_count_q;
    largest_d   = largest_q;
    sel_d       = sel_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    dig_d       = dig_q;
    rv_d        = 1'b0;
    ram_we      = 1'b0;
    wr_other    = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = rdata;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    cnt_cmd     = '{op: CNT_IDLE, sel: '0};

    unique case (state_q)
      ST_LOAD: begin
        if (keys_i.valid) begin
          // Store while there is room; drop the rest.
          if (key_count_q < MaxCnt) begin
            ram_we      = 1'b1;
            ram_waddr   = key_count_q[AddrW-1:0];
            ram_wdata   = key_in;
            key_count_d = key_count_q + CntW'(1);
            if (key_in > largest_q) begin
              largest_d = key_in;
            end
          end
          if (keys_i.last_key) begin
            pos_d   = '0;
            state_d = ST_CLR;
          end
        end
      end

      ST_CLR: begin
        if (pos_q >= span) begin
          idx_d   = '0;
          state_d = ST_OUT_RD;
        end else begin
          cnt_cmd.op = CNT_CLEAR;
          idx_d      = '0;
          state_d    = ST_COUNT;
        end
      end

      ST_COUNT: begin
        // Issue reads front to back; count the digit of the key read last cycle.
        if (idx_q != key_count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AddrW-1:0];
          idx_d     = idx_q + CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          cnt_cmd = '{op: CNT_INC, sel: rd_digit};
        end
        if (idx_q == key_count_q && !rv_q) begin
          dig_d   = '0;
          state_d = ST_PREFIX;
        end
      end

      ST_PREFIX: begin
        cnt_cmd = '{op: CNT_PREFIX, sel: dig_q};
        dig_d   = dig_q + RadixW'(1);
        if (dig_q == TopDigit) begin
          idx_d   = key_count_q;
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        // Issue reads back to front; place each key at its decremented slot.
        if (idx_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = AddrW'(idx_q - CntW'(1));
          idx_d     = idx_q - CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          cnt_cmd   = '{op: CNT_DEC, sel: rd_digit};
          ram_we    = 1'b1;
          wr_other  = 1'b1;
          ram_waddr = cnt_res[AddrW-1:0];
          ram_wdata = rdata;
        end
        if (idx_q == '0 && !rv_q) begin
          sel_d   = ~sel_q;
          pos_d   = pos_q + PosW'(1);
          state_d = ST_CLR;
        end
      end

      ST_OUT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q[AddrW-1:0];
        state_d   = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        // Hold the key on the port until taken.
        if (keys_o.ready) begin
          if (out_last) begin
            key_count_d = '0;
            largest_d   = '0;
            state_d     = ST_LOAD;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  assign wr_sel = sel_q ^ wr_other;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      key_count_q <= '0;
      largest_q   <= '0;
      sel_q       <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
      dig_q       <= '0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      largest_q   <= largest_d;
      sel_q       <= sel_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      dig_q       <= dig_d;
      rv_q        <= rv_d;
    end
  end

  lrs_key_ram #(.Depth(MAX_KEYS)) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (ram_we && !wr_sel),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_a)
  );

  lrs_key_ram #(.Depth(MAX_KEYS)) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (ram_we && wr_sel),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_b)
  );

  lrs_digit_cnt #(.MaxKeys(MAX_KEYS)) u_digit_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cnt_cmd),
    .result_o (cnt_res)
  );

`ifndef SYNTHESIS
  // Loading and emitting never overlap.
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(keys_o.valid && keys_i.ready))
    else $error("input ready while a sorted key is shown");

  // Placement stays inside the loaded key range.
  a_place_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLACE && rv_q) |-> (cnt_res < key_count_q))
    else $error("placement slot beyond key count");

  // The key count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= MaxCnt)
    else $error("key count overflow");

  // Taking the last sorted key returns the block to loading.
  a_last_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (keys_o.valid && keys_o.ready && keys_o.last_out) |=>
      (keys_i.ready && key_count_q == '0))
    else $error("block not back to loading after last key");
`endif

endmodule

FILE: hw/rtl/lrs_key_ram.sv
// Single-write, single-read key buffer with registered read data.
module lrs_key_ram #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic [lrs_pkg::KeyW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_i,
  output logic [lrs_pkg::KeyW-1:0] rdata_o
);
  import lrs_pkg::*;

  logic [KeyW-1:0] mem_q [Depth];
  logic [KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lrs_digit_cnt.sv
// Ten digit counters around one shared adder: clear, increment, prefix, decrement.
module lrs_digit_cnt #(
  parameter int unsigned MaxKeys = 64,
  localparam int unsigned CntW = $clog2(MaxKeys + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrs_pkg::cnt_cmd_t  cmd_i,
  output logic [CntW-1:0]    result_o
);
  import lrs_pkg::*;

  logic [CntW-1:0] cnt_q [NumRadix];
  logic [CntW-1:0] acc_q, acc_d;
  logic [CntW-1:0] opa, opb, sum;

  // One read port: the selected counter.
  assign opa = cnt_q[cmd_i.sel];

  always_comb begin
    case (cmd_i.op)
      CNT_INC:    opb = CntW'(1);
      CNT_DEC:    opb = '1;
      CNT_PREFIX: opb = acc_q;
      default:    opb = '0;
    endcase
  end

  assign sum      = opa + opb;
  assign result_o = sum;

  // Running total for the prefix sweep.
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.op == CNT_CLEAR) begin
      acc_d = '0;
    end else if (cmd_i.op == CNT_PREFIX) begin
      acc_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      for (int d = 0; d < NumRadix; d++) begin
        cnt_q[d] <= '0;
      end
    end else begin
      acc_q <= acc_d;
      if (cmd_i.op == CNT_CLEAR) begin
        for (int d = 0; d < NumRadix; d++) begin
          cnt_q[d] <= '0;
        end
      end else if (cmd_i.op == CNT_INC || cmd_i.op == CNT_DEC ||
                   cmd_i.op == CNT_PREFIX) begin
        cnt_q[cmd_i.sel] <= sum;
      end
    end
  end

endmodule
